// File: hdl/pasm_pkg.sv
`default_nettype none
package pasm_pkg;

  localparam int MAX_TERMS  = 32;
  localparam int COEFF_W    = 16;
  localparam int IDX_W      = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

  localparam int OPC_W      = 2;
  localparam int TERM_W     = 5;
  localparam int COEFF_IN_W = 16;
  localparam int CFG_W      = 5;
  localparam int DEG_W      = 6;
  localparam int SUM_W      = 18;
  localparam int ACC_W      = 37;
  localparam int PROD_W     = 2 * COEFF_W;

  localparam int IN_BITS      = TERM_W + COEFF_IN_W;
  localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS     = DEG_W + 2 * SUM_W + ACC_W;
  localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [OPC_W-1:0] OP_LOAD_A  = 2'd0;
  localparam logic [OPC_W-1:0] OP_LOAD_B  = 2'd1;
  localparam logic [OPC_W-1:0] OP_COMPUTE = 2'd2;

  localparam logic CFG_A_DEGREE = 1'b0;
  localparam logic CFG_B_DEGREE = 1'b1;

  typedef struct packed {
    logic clr;
    logic en;
  } mac_ctrl_t;

endpackage
`default_nettype wire

// File: hdl/pasm_ram.sv
`default_nettype none
module pasm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// File: hdl/pasm_mac.sv
`default_nettype none
module pasm_mac (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire pasm_pkg::mac_ctrl_t                ctrl,
  input  wire logic signed [pasm_pkg::COEFF_W-1:0] a_in,
  input  wire logic signed [pasm_pkg::COEFF_W-1:0] b_in,
  output logic signed      [pasm_pkg::ACC_W-1:0]   acc,
  output logic                                    busy
);
  import pasm_pkg::*;

  logic signed [PROD_W-1:0] prod_r;
  logic                     prod_vld_r;
  logic signed [ACC_W-1:0]  acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= ctrl.en;
    end
    prod_r <= a_in * b_in;
    if (ctrl.clr) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  assign acc  = acc_r;
  assign busy = prod_vld_r;

endmodule
`default_nettype wire

// File: hdl/polynomial_add_sub_mul.sv
// Polynomial add, subtract and multiply engine.
// The input stream carries an opcode in in_tuser. A load transaction writes one
// signed coefficient of A or B at the power given in in_tdata.
// A compute transaction emits one result per power, from a_degree + b_degree
// down to zero, with the coefficients of A+B, A-B and A*B; out_tlast marks the
// power-zero result. Degrees are to be written on the cfg channel only while
// the block idles; the block itself does not enforce this. Each power is
// produced by one shared 16x16 multiplier and accumulator fed from two
// coefficient RAMs under a small sequencer: it reads the coefficients of that
// power, issues each product term in turn, then drains the pipeline. The
// receiver can stall each result; the block is not ready during a compute.
// A result is held in the output register until out_tready takes it.
// Reset clears the degrees and marks every stored coefficient as zero at once.
`default_nettype none
module polynomial_add_sub_mul (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  // term_index [4:0], coefficient [20:5]
  input  wire logic [pasm_pkg::IN_TDATA_W-1:0]      in_tdata,
  // opcode [1:0]
  input  wire logic [pasm_pkg::OPC_W-1:0]           in_tuser,
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  // out_degree [5:0], sum_coeff [23:6], diff_coeff [41:24], product_coeff [78:42]
  output logic      [pasm_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                      out_tlast,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic                                 cfg_index,
  input  wire logic [pasm_pkg::CFG_W-1:0]           cfg_data
);
  import pasm_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_SUMRD, S_MAC, S_DRAIN, S_OUT} state_t;

  state_t                    state_r, state_nxt;
  logic [DEG_W-1:0]          p_r, p_nxt;
  logic [IDX_W-1:0]          i_r, i_nxt;
  logic                      out_tvalid_r, out_tvalid_nxt;
  logic [CFG_W-1:0]          a_degree_r, b_degree_r;
  logic [MAX_TERMS-1:0]      a_vld_r, b_vld_r;
  logic                      s1_vld_r, s1_sum_r, s1_za_r, s1_zb_r;
  logic signed [SUM_W-1:0]   sum_r, diff_r;

  logic                      in_accept;
  logic [TERM_W-1:0]         in_term_index;
  logic [COEFF_IN_W-1:0]     in_coefficient;
  logic                      load_ok, a_we, b_we;
  logic [IDX_W-1:0]          da, db, lo, hi, a_raddr, b_raddr;
  logic [DEG_W-1:0]          top;
  logic                      iss_vld, iss_sum, iss_za, iss_zb;
  logic [COEFF_W-1:0]        a_rd, b_rd;
  logic signed [COEFF_W-1:0] a_val, b_val;
  logic signed [ACC_W-1:0]   acc;
  logic                      mac_busy;
  mac_ctrl_t                 mac_ctrl;

  assign in_accept      = in_tvalid && in_tready;
  assign in_term_index  = in_tdata[TERM_W-1:0];
  assign in_coefficient = in_tdata[IN_BITS-1:TERM_W];
  assign load_ok        = 32'(in_term_index) < MAX_TERMS;
  assign a_we           = in_accept && (in_tuser == OP_LOAD_A) && load_ok;
  assign b_we           = in_accept && (in_tuser == OP_LOAD_B) && load_ok;

  assign da  = (32'(a_degree_r) > MAX_TERMS - 1) ? IDX_W'(MAX_TERMS - 1)
                                                 : a_degree_r[IDX_W-1:0];
  assign db  = (32'(b_degree_r) > MAX_TERMS - 1) ? IDX_W'(MAX_TERMS - 1)
                                                 : b_degree_r[IDX_W-1:0];
  assign top = DEG_W'(da) + DEG_W'(db);
  assign lo  = (p_r > DEG_W'(db)) ? IDX_W'(p_r - DEG_W'(db)) : '0;
  assign hi  = (p_r < DEG_W'(da)) ? IDX_W'(p_r) : da;

  always_comb begin
    a_raddr = i_r;
    b_raddr = IDX_W'(p_r - DEG_W'(i_r));
    iss_za  = 1'b0;
    iss_zb  = 1'b0;
    if (state_r == S_SUMRD) begin
      a_raddr = IDX_W'(p_r);
      b_raddr = IDX_W'(p_r);
      iss_za  = p_r > DEG_W'(da);
      iss_zb  = p_r > DEG_W'(db);
    end
    iss_za = iss_za || !a_vld_r[a_raddr];
    iss_zb = iss_zb || !b_vld_r[b_raddr];
  end

  pasm_ram #(.WIDTH(COEFF_W), .DEPTH(MAX_TERMS)) u_ram_a (
    .clk   (clk),
    .we    (a_we),
    .waddr (in_term_index[IDX_W-1:0]),
    .wdata (COEFF_W'(in_coefficient)),
    .raddr (a_raddr),
    .rdata (a_rd)
  );

  pasm_ram #(.WIDTH(COEFF_W), .DEPTH(MAX_TERMS)) u_ram_b (
    .clk   (clk),
    .we    (b_we),
    .waddr (in_term_index[IDX_W-1:0]),
    .wdata (COEFF_W'(in_coefficient)),
    .raddr (b_raddr),
    .rdata (b_rd)
  );

  assign a_val = s1_za_r ? '0 : a_rd;
  assign b_val = s1_zb_r ? '0 : b_rd;

  assign mac_ctrl.clr = (state_r == S_SUMRD);
  assign mac_ctrl.en  = s1_vld_r && !s1_sum_r;

  pasm_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (mac_ctrl),
    .a_in  (a_val),
    .b_in  (b_val),
    .acc   (acc),
    .busy  (mac_busy)
  );

  always_comb begin
    state_nxt      = state_r;
    p_nxt          = p_r;
    i_nxt          = i_r;
    out_tvalid_nxt = out_tvalid_r;
    iss_vld        = 1'b0;
    iss_sum        = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept && (in_tuser == OP_COMPUTE)) begin
          p_nxt     = top;
          state_nxt = S_SUMRD;
        end
      end
      S_SUMRD: begin
        iss_vld   = 1'b1;
        iss_sum   = 1'b1;
        i_nxt     = lo;
        state_nxt = S_MAC;
      end
      S_MAC: begin
        iss_vld = 1'b1;
        i_nxt   = i_r + IDX_W'(1);
        if (i_r == hi) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!s1_vld_r && !mac_busy) begin
          out_tvalid_nxt = 1'b1;
          state_nxt      = S_OUT;
        end
      end
      S_OUT: begin
        if (out_tready) begin
          out_tvalid_nxt = 1'b0;
          if (p_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            p_nxt     = p_r - DEG_W'(1);
            state_nxt = S_SUMRD;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
      s1_vld_r     <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      s1_vld_r     <= iss_vld;
    end
    p_r      <= p_nxt;
    i_r      <= i_nxt;
    s1_sum_r <= iss_sum;
    s1_za_r  <= iss_za;
    s1_zb_r  <= iss_zb;
    if (s1_vld_r && s1_sum_r) begin
      sum_r  <= SUM_W'(a_val) + SUM_W'(b_val);
      diff_r <= SUM_W'(a_val) - SUM_W'(b_val);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r    <= '0;
      b_vld_r    <= '0;
      a_degree_r <= '0;
      b_degree_r <= '0;
    end else begin
      if (a_we) begin
        a_vld_r[in_term_index[IDX_W-1:0]] <= 1'b1;
      end
      if (b_we) begin
        b_vld_r[in_term_index[IDX_W-1:0]] <= 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_A_DEGREE) begin
          a_degree_r <= cfg_data;
        end else begin
          b_degree_r <= cfg_data;
        end
      end
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tlast  = (p_r == '0);
  assign out_tdata  = OUT_TDATA_W'({acc, diff_r, sum_r, p_r});

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input accepted while a result is pending");

  a_last_degree: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tdata[DEG_W-1:0] == '0)))
    else $error("tlast does not match degree zero");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> in_tready)
    else $error("block not idle after the final result");

  a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == OP_COMPUTE)) |=> !in_tready)
    else $error("block ready right after a compute transaction");

endmodule
`default_nettype wire
